### hw/rtl/stc8_pkg.sv
// Shared types, constants and CRC helpers for the sensor transaction CRC-8 checker.
// No dependencies; used by the interfaces, the update logic and the top level.
package stc8_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] LOW_NIBBLE = 8'h0F;
    localparam logic [7:0] TOP_BIT    = 8'h80;

    localparam logic [7:0] WR_OPCODE_RESET = 8'd6;
    localparam logic [7:0] RD_OPCODE_RESET = 8'd7;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register indexes, taken from paddr[2]
    localparam logic REG_WR_OPCODE = 1'b0;
    localparam logic REG_RD_OPCODE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_SENT     = 2'd1,
        CMD_RECEIVED = 2'd2,
        CMD_CHECKSUM = 2'd3
    } cmd_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [BYTE_W-1:0]  crc;
        logic [BYTE_W-1:0]  status_copy;
        logic [COUNT_W-1:0] sent_count;
        logic [BYTE_W-1:0]  first_opcode;
        logic               acks_good;
        logic [BYTE_W-1:0]  last_received;
    } track_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] crc_now;
        logic              checksum_ok;
        logic [BYTE_W-1:0] status_now;
        logic              status_updated;
    } result_t;

    function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    // MSB-first fold of one byte, no reflection, no final XOR
    function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if ((c & TOP_BIT) != '0)
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hw/rtl/stc8_if.sv
// Valid/ready channel interfaces for transaction words and result words.
// Depends on stc8_pkg for field widths.
interface stc8_in_if;
    logic                           valid;
    logic                           ready;
    logic [stc8_pkg::CMD_W-1:0]     command;
    logic [stc8_pkg::BYTE_W-1:0]    data_byte;
    logic                           acked;

    modport source (output valid, output command, output data_byte, output acked,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input acked,
                    output ready);
endinterface

interface stc8_out_if;
    logic                           valid;
    logic                           ready;
    logic [stc8_pkg::BYTE_W-1:0]    crc_now;
    logic                           checksum_ok;
    logic [stc8_pkg::BYTE_W-1:0]    status_now;
    logic                           status_updated;

    modport source (output valid, output crc_now, output checksum_ok,
                    output status_now, output status_updated, input ready);
    modport sink   (input valid, input crc_now, input checksum_ok,
                    input status_now, input status_updated, output ready);
endinterface

### hw/rtl/sensor_transaction_crc8_checker_core.sv
// Sensor transaction CRC-8 checker, top level.
// An accepted word is held in the input register, and its result word in the result register.
// Throughput: one word per cycle unless chk stalls; the tracking state updates in the same cycle as the result.
// Reset: rst_n asynchronous, active low; clears tracking state but sets acks_good, clears pipeline valids, and loads
// the opcode registers with 6 (status write) and 7 (status read).
// Depends on stc8_pkg, stc8_if (stc8_in_if, stc8_out_if) and stc8_update.
module sensor_transaction_crc8_checker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    stc8_in_if.sink                         txn,
    stc8_out_if.source                      chk,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stc8_pkg::ADDR_W-1:0]     paddr,
    input  logic [stc8_pkg::DATA_W-1:0]     pwdata,
    output logic [stc8_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [stc8_pkg::BYTE_W-1:0] wr_opcode_reg;
    logic [stc8_pkg::BYTE_W-1:0] rd_opcode_reg;

    logic                        in_valid_reg;
    logic [stc8_pkg::CMD_W-1:0]  cmd_reg;
    logic [stc8_pkg::BYTE_W-1:0] byte_reg;
    logic                        ack_reg;

    stc8_pkg::track_state_t      state_reg;
    stc8_pkg::track_state_t      state_next;
    stc8_pkg::result_t           res_next;

    logic                        out_valid_reg;
    stc8_pkg::result_t           res_reg;

    logic                        out_free;
    logic                        advance;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            stc8_pkg::REG_WR_OPCODE: prdata[stc8_pkg::BYTE_W-1:0] = wr_opcode_reg;
            stc8_pkg::REG_RD_OPCODE: prdata[stc8_pkg::BYTE_W-1:0] = rd_opcode_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_opcode_reg <= stc8_pkg::WR_OPCODE_RESET;
            rd_opcode_reg <= stc8_pkg::RD_OPCODE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == stc8_pkg::REG_WR_OPCODE)
                wr_opcode_reg <= pwdata[stc8_pkg::BYTE_W-1:0];
            else
                rd_opcode_reg <= pwdata[stc8_pkg::BYTE_W-1:0];
        end
    end

    // Result register is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || chk.ready;
    assign advance   = in_valid_reg && out_free;
    assign txn.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (txn.ready)
            in_valid_reg <= txn.valid;
    end

    always_ff @(posedge clk)
    begin
        if (txn.ready && txn.valid)
        begin
            cmd_reg  <= txn.command;
            byte_reg <= txn.data_byte;
            ack_reg  <= txn.acked;
        end
    end

    stc8_update u_update (
        .cur       (state_reg),
        .command   (cmd_reg),
        .data_byte (byte_reg),
        .acked     (ack_reg),
        .wr_opcode (wr_opcode_reg),
        .rd_opcode (rd_opcode_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= '{acks_good: 1'b1, default: '0};
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign chk.valid          = out_valid_reg;
    assign chk.crc_now        = res_reg.crc_now;
    assign chk.checksum_ok    = res_reg.checksum_ok;
    assign chk.status_now     = res_reg.status_now;
    assign chk.status_updated = res_reg.status_updated;

endmodule

### hw/rtl/stc8_update.sv
// Next-state and result logic for one transaction word.
// Depends on stc8_pkg for the state struct, command codes and CRC helpers.
module stc8_update (
    input  stc8_pkg::track_state_t          cur,
    input  logic [stc8_pkg::CMD_W-1:0]      command,
    input  logic [stc8_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            acked,
    input  logic [stc8_pkg::BYTE_W-1:0]     wr_opcode,
    input  logic [stc8_pkg::BYTE_W-1:0]     rd_opcode,
    output stc8_pkg::track_state_t          nxt,
    output stc8_pkg::result_t               res
);

    logic [stc8_pkg::BYTE_W-1:0] folded;
    logic [stc8_pkg::BYTE_W-1:0] seed;
    logic                        acks_next;
    logic                        match;
    logic                        updated;

    assign folded    = stc8_pkg::crc_fold(cur.crc, data_byte);
    assign seed      = stc8_pkg::bit_reverse(cur.status_copy & stc8_pkg::LOW_NIBBLE);
    assign acks_next = cur.acks_good & acked;
    assign match     = (stc8_pkg::bit_reverse(data_byte) == cur.crc);

    always_comb
    begin
        nxt     = cur;
        updated = 1'b0;
        case (stc8_pkg::cmd_t'(command))
            stc8_pkg::CMD_START:
            begin
                nxt.crc           = seed;
                nxt.sent_count    = '0;
                nxt.acks_good     = 1'b1;
                nxt.first_opcode  = '0;
                nxt.last_received = '0;
            end
            stc8_pkg::CMD_SENT:
            begin
                nxt.crc       = folded;
                nxt.acks_good = acks_next;
                if (cur.sent_count == '0)
                    nxt.first_opcode = data_byte;
                else if (cur.sent_count == stc8_pkg::COUNT_W'(1)
                         && cur.first_opcode == wr_opcode && acks_next)
                begin
                    nxt.status_copy = data_byte;
                    updated         = 1'b1;
                end
                // saturate
                if (cur.sent_count != stc8_pkg::COUNT_MAX)
                    nxt.sent_count = cur.sent_count + stc8_pkg::COUNT_W'(1);
            end
            stc8_pkg::CMD_RECEIVED:
            begin
                nxt.crc           = folded;
                nxt.last_received = data_byte;
            end
            default:
            begin
                if (match && cur.sent_count == stc8_pkg::COUNT_W'(1)
                    && cur.first_opcode == rd_opcode)
                begin
                    nxt.status_copy = cur.last_received;
                    updated         = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        res.crc_now        = nxt.crc;
        res.checksum_ok    = (stc8_pkg::cmd_t'(command) == stc8_pkg::CMD_CHECKSUM) && match;
        res.status_now     = nxt.status_copy;
        res.status_updated = updated;
    end

endmodule

### tb/crc8_wire_pkg.sv
`timescale 1ns / 100ps
// CRC-8 arithmetic (polynomial 0x31, MSB first) used by the checker and the stimulus.
// Stands alone; depends on nothing.
package crc8_wire_pkg;

    localparam logic [7:0] WIRE_POLY = 8'h31;

    // fold one byte into the running CRC, no reflection, no final xor
    function automatic logic [7:0] fold8(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
        begin
            c = c[7] ? ((c << 1) ^ WIRE_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] flip8(input logic [7:0] v);
        return {<<{v}};
    endfunction

endpackage

### tb/crc8_result_checker.sv
`timescale 1ns / 100ps
// Watches the transaction, result and register channels, tracks the sensor transaction
// state and compares every result word. Depends on stc8_pkg, stc8_if and crc8_wire_pkg.
module crc8_result_checker
    import stc8_pkg::*;
    import crc8_wire_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    stc8_in_if                  txn,
    stc8_out_if                 chk,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output int                  fail_count,
    output int                  checked_count,
    output int                  outstanding,
    output int                  match_count,
    output int                  store_count,
    output logic [BYTE_W-1:0]   status_state
);

    localparam int MAX_REPORTS = 10;

    logic [BYTE_W-1:0]  wr_code;
    logic [BYTE_W-1:0]  rd_code;
    logic [BYTE_W-1:0]  crc_acc;
    logic [BYTE_W-1:0]  status_reg;
    logic [COUNT_W-1:0] sent_cnt;
    logic [BYTE_W-1:0]  first_sent;
    logic               acks_all;
    logic [BYTE_W-1:0]  last_rx;

    result_t due_results[$];
    result_t got;
    result_t want;
    int      fails;
    int      checked;
    int      match_hits;
    int      stores;

    function automatic result_t track_word(input cmd_t c, input logic [BYTE_W-1:0] b,
                                           input logic a);
        result_t r;
        r = '0;
        case (c)
            CMD_START:
            begin
                crc_acc    = flip8(status_reg & LOW_NIBBLE);
                sent_cnt   = '0;
                acks_all   = 1'b1;
                first_sent = '0;
                last_rx    = '0;
            end
            CMD_SENT:
            begin
                crc_acc  = fold8(crc_acc, b);
                acks_all = acks_all & a;
                if (sent_cnt == 0)
                    first_sent = b;
                else if (sent_cnt == 1 && first_sent == wr_code && acks_all)
                begin
                    status_reg       = b;
                    r.status_updated = 1'b1;
                end
                if (sent_cnt != COUNT_MAX)
                    sent_cnt = sent_cnt + 1'b1;
            end
            CMD_RECEIVED:
            begin
                crc_acc = fold8(crc_acc, b);
                last_rx = b;
            end
            default:
            begin
                r.checksum_ok = (flip8(b) == crc_acc);
                // a read of the status register stores the byte it returned
                if (r.checksum_ok && sent_cnt == 1 && first_sent == rd_code)
                begin
                    status_reg       = last_rx;
                    r.status_updated = 1'b1;
                end
            end
        endcase
        r.crc_now    = crc_acc;
        r.status_now = status_reg;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_code    = WR_OPCODE_RESET;
            rd_code    = RD_OPCODE_RESET;
            crc_acc    = '0;
            status_reg = '0;
            sent_cnt   = '0;
            first_sent = '0;
            acks_all   = 1'b1;
            last_rx    = '0;
            due_results.delete();
            fails      = 0;
            checked    = 0;
            match_hits = 0;
            stores     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WR_OPCODE)
                    wr_code = pwdata[BYTE_W-1:0];
                else
                    rd_code = pwdata[BYTE_W-1:0];
            end

            if (chk.valid && chk.ready)
            begin
                got.crc_now        = chk.crc_now;
                got.checksum_ok    = chk.checksum_ok;
                got.status_now     = chk.status_now;
                got.status_updated = chk.status_updated;
                if (due_results.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("result word with none due: crc=%02h ok=%0b status=%02h upd=%0b",
                                 got.crc_now, got.checksum_ok, got.status_now,
                                 got.status_updated);
                end
                else
                begin
                    want = due_results.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display({"result word %0d: expected crc=%02h ok=%0b status=%02h ",
                                      "upd=%0b, got crc=%02h ok=%0b status=%02h upd=%0b"},
                                     checked, want.crc_now, want.checksum_ok, want.status_now,
                                     want.status_updated, got.crc_now, got.checksum_ok,
                                     got.status_now, got.status_updated);
                    end
                end
            end

            if (txn.valid && txn.ready)
            begin
                want = track_word(cmd_t'(txn.command), txn.data_byte, txn.acked);
                if (want.checksum_ok)
                    match_hits++;
                if (want.status_updated)
                    stores++;
                due_results.push_back(want);
            end
        end

        fail_count    <= fails;
        checked_count <= checked;
        outstanding   <= due_results.size();
        match_count   <= match_hits;
        store_count   <= stores;
        status_state  <= status_reg;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the CRC-8 transaction checker bench: clock, reset, stimulus and verdict.
// Depends on stc8_pkg, stc8_if, crc8_wire_pkg, crc8_result_checker and the core.
module tb_top;
    import stc8_pkg::*;
    import crc8_wire_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_WORDS    = 306;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 checked_count;
    int                 outstanding;
    int                 match_count;
    int                 store_count;
    logic [BYTE_W-1:0]  status_state;

    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 words_sent = 0;
    int                 quiet_cycles = 0;
    logic [BYTE_W-1:0]  wire_crc = '0;
    logic [BYTE_W-1:0]  cur_wr_op = WR_OPCODE_RESET;
    logic [BYTE_W-1:0]  cur_rd_op = RD_OPCODE_RESET;

    stc8_in_if  txn_bus();
    stc8_out_if chk_bus();

    sensor_transaction_crc8_checker_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .txn     (txn_bus),
        .chk     (chk_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    crc8_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .txn           (txn_bus),
        .chk           (chk_bus),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .outstanding   (outstanding),
        .match_count   (match_count),
        .store_count   (store_count),
        .status_state  (status_state)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        chk_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (txn_bus.valid && txn_bus.ready) || (chk_bus.valid && chk_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one transaction word and keep the wire-side CRC in step with it.
    // The status seen right after a start's handshake is the one the start seeded from.
    task automatic send_word(input cmd_t c, input logic [BYTE_W-1:0] b, input logic a);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            txn_bus.valid <= 1'b0;
            @(posedge clk);
        end
        txn_bus.valid     <= 1'b1;
        txn_bus.command   <= c;
        txn_bus.data_byte <= b;
        txn_bus.acked     <= a;
        do
            @(posedge clk);
        while (!txn_bus.ready);
        words_sent++;
        case (c)
            CMD_START:    wire_crc = flip8(status_state & LOW_NIBBLE);
            CMD_SENT,
            CMD_RECEIVED: wire_crc = fold8(wire_crc, b);
            default:      ;
        endcase
    endtask

    task automatic wait_drained();
        txn_bus.valid <= 1'b0;
        wait (checked_count == words_sent);
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-BYTE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_opcodes(input logic [BYTE_W-1:0] wr_op, input logic [BYTE_W-1:0] rd_op);
        wait_drained();
        write_reg(REG_WR_OPCODE, wr_op);
        write_reg(REG_RD_OPCODE, rd_op);
        cur_wr_op = wr_op;
        cur_rd_op = rd_op;
    endtask

    task automatic random_transaction();
        int                pick;
        int                n_sent;
        int                n_recv;
        logic [BYTE_W-1:0] op;
        pick = int'($urandom_range(99));
        if (pick < 12)
        begin
            // noise: loose words of any kind
            repeat ($urandom_range(1, 4))
                send_word(cmd_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            return;
        end
        if (pick < 42)
        begin
            op     = cur_wr_op;
            n_sent = ($urandom_range(7) == 0) ? int'($urandom_range(1, 4)) : 2;
            n_recv = ($urandom_range(3) == 0) ? 1 : 0;
        end
        else if (pick < 72)
        begin
            op     = cur_rd_op;
            n_sent = ($urandom_range(7) == 0) ? 2 : 1;
            n_recv = int'($urandom_range(1, 2));
        end
        else
        begin
            op     = BYTE_W'($urandom_range(255));
            n_sent = int'($urandom_range(1, 4));
            n_recv = int'($urandom_range(0, 3));
        end
        send_word(CMD_START, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < n_sent; i++)
            send_word(CMD_SENT, (i == 0) ? op : BYTE_W'($urandom_range(255)),
                      $urandom_range(9) != 0);
        for (int i = 0; i < n_recv; i++)
            send_word(CMD_RECEIVED, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        if ($urandom_range(4) != 0)
            send_word(CMD_CHECKSUM,
                      ($urandom_range(4) != 0) ? flip8(wire_crc) : BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
    endtask

    task automatic directed_words();
        // no start seen yet: words act on the reset state
        send_word(CMD_CHECKSUM, 8'h00, 1'b0);
        send_word(CMD_RECEIVED, 8'hFF, 1'b1);
        send_word(CMD_SENT, 8'h00, 1'b0);
        send_word(CMD_CHECKSUM, 8'hFF, 1'b1);
        // status write, then bytes past the second and a saturated count
        send_word(CMD_START, 8'hFF, 1'b1);
        send_word(CMD_SENT, cur_wr_op, 1'b1);
        send_word(CMD_SENT, 8'hFF, 1'b1);
        send_word(CMD_SENT, 8'h00, 1'b1);
        send_word(CMD_SENT, 8'h80, 1'b0);
        send_word(CMD_SENT, 8'h01, 1'b1);
        // missing ack on the opcode blocks the store
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_SENT, cur_wr_op, 1'b0);
        send_word(CMD_SENT, 8'h55, 1'b1);
        // status read with a good checksum
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_SENT, cur_rd_op, 1'b1);
        send_word(CMD_RECEIVED, 8'h3C, 1'b0);
        send_word(CMD_CHECKSUM, flip8(wire_crc), 1'b0);
        // status read with a bad checksum
        send_word(CMD_START, 8'hFF, 1'b1);
        send_word(CMD_SENT, cur_rd_op, 1'b0);
        send_word(CMD_RECEIVED, 8'hA5, 1'b1);
        send_word(CMD_CHECKSUM, flip8(wire_crc) ^ 8'h01, 1'b1);
        // write zero, then seed from it
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_SENT, cur_wr_op, 1'b1);
        send_word(CMD_SENT, 8'h00, 1'b1);
        send_word(CMD_START, 8'hFF, 1'b1);
    endtask

    initial
    begin
        int                tx_mix[4];
        int                rx_mix[4];
        logic [BYTE_W-1:0] wr_mix[4];
        logic [BYTE_W-1:0] rd_mix[4];
        int                target;

        tx_mix = '{0, 77, 0, 21};
        rx_mix = '{0, 0, 77, 21};
        wr_mix = '{8'h00, 8'hFF, 8'h00, 8'h5A};
        rd_mix = '{8'hFF, 8'h00, 8'h00, 8'h5A};
        wr_mix[2] = BYTE_W'($urandom_range(255));
        rd_mix[2] = BYTE_W'($urandom_range(255));

        txn_bus.valid     = 1'b0;
        txn_bus.command   = CMD_START;
        txn_bus.data_byte = '0;
        txn_bus.acked     = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_opcodes(wr_mix[ph], rd_mix[ph]);
            tx_idle_pct  = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            target = words_sent + PHASE_WORDS / 2;
            while (words_sent < target)
                random_transaction();
            // hold until everything in flight has come back
            wait_drained();
            target = words_sent + PHASE_WORDS / 2;
            while (words_sent < target)
                random_transaction();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d words sent through directed cases and four idle/stall mixes, %0d checked",
                 words_sent, checked_count);
        $display("five opcode settings; %0d checksum matches and %0d status stores among them",
                 match_count, store_count);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/stc8_pkg.sv
hw/rtl/stc8_if.sv
hw/rtl/stc8_update.sv
hw/rtl/sensor_transaction_crc8_checker_core.sv
tb/crc8_wire_pkg.sv
tb/crc8_result_checker.sv
tb/tb_top.sv
